// ===== rtl/lls_pkg.sv =====
// package for the log line splitter
// holds item kind codes and character constants, no dependencies
package lls_pkg;

  typedef logic [1:0] kind_t;
  typedef logic [7:0] char_t;

  localparam kind_t KIND_START = 2'd0;
  localparam kind_t KIND_DATA  = 2'd1;
  localparam kind_t KIND_END   = 2'd2;

  localparam char_t CH_ESC      = 8'h1B;
  localparam char_t CH_LBRACKET = 8'h5B;
  localparam char_t CH_SEMI     = 8'h3B;
  localparam char_t CH_NL       = 8'h0A;
  localparam char_t CH_DIGIT_LO = 8'h30;
  localparam char_t CH_DIGIT_HI = 8'h39;

  localparam int REG_WIDTH = 32;

endpackage

// ===== rtl/log_line_splitter_csi_atomic.sv =====
// top level of the log line splitter: apb registers, sequencer, output register
// depends on lls_pkg, lls_fill_unit and lls_param_store
//
// Each accepted text byte is turned into record start, data and record end
// transactions. A byte that produces nothing (ESC, '[' after ESC, a held csi
// parameter, a newline with no open record) leaves the block idle and ready.
// A newline that closes an open record emits the record end from S_END_NL.
// Any other byte keeps the block busy, not ready for a new byte, while S_FIT
// checks the fit and then S_CHK and S_DATA place each data byte in turn, with
// a record end forced in S_CHK inside an oversized sequence; each state that
// emits waits while the output is stalled. Record start and end transactions
// otherwise go out in states that are passed anyway. The sequencer runs every
// fit check and fill update through one adder and compare.
// Csi sequences are held (up to CSI_MAX parameter bytes) and released whole.
module log_line_splitter_csi_atomic #(
  parameter int LINE_LEN = 256,
  parameter int CSI_MAX = 16,
  parameter int HEADER_BYTES = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_text_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_item_kind,
  output logic [7:0]  out_data_byte,
  output logic [2:0]  out_record_severity,
  output logic        out_record_expedited,
  output logic        out_last_of_run,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int FW = $clog2(LINE_LEN + 1);
  localparam int NW = $clog2(CSI_MAX + 4);
  localparam int SW = $clog2(LINE_LEN + CSI_MAX + 4);
  localparam int CW = $clog2(CSI_MAX + 1);
  localparam int AW = $clog2(CSI_MAX);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_FIT    = 3'd1;
  localparam logic [2:0] S_CHK    = 3'd2;
  localparam logic [2:0] S_DATA   = 3'd3;
  localparam logic [2:0] S_END_NL = 3'd4;

  localparam logic [1:0] PH_TEXT = 2'd0;
  localparam logic [1:0] PH_ESC  = 2'd1;
  localparam logic [1:0] PH_CSI  = 2'd2;

  localparam logic [1:0] SRC_ESC = 2'd0;
  localparam logic [1:0] SRC_LB  = 2'd1;
  localparam logic [1:0] SRC_PAR = 2'd2;
  localparam logic [1:0] SRC_FIN = 2'd3;

  localparam logic REG_SEVERITY  = 1'b0;
  localparam logic REG_EXPEDITED = 1'b1;

  logic [2:0]     sev_r;
  logic           exp_r;

  logic [2:0]     state_r, state_nxt;
  logic [1:0]     phase_r, phase_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic [AW-1:0]  idx_r, idx_nxt;
  logic [FW-1:0]  fill_r, fill_nxt;
  logic [NW-1:0]  n_r, n_nxt;
  lls_pkg::char_t byte_r, byte_nxt;
  logic [1:0]     src_r, src_nxt;
  logic           csi_r, csi_nxt;
  logic           force_r, force_nxt;

  logic               out_valid_r;
  lls_pkg::kind_t     out_kind_r;
  lls_pkg::char_t     out_byte_r;
  logic [2:0]         out_sev_r;
  logic               out_exp_r;
  logic               out_last_r;

  logic               emit;
  lls_pkg::kind_t     e_kind;
  lls_pkg::char_t     e_byte;
  logic               e_last;
  logic               can_emit;
  logic               wr_en;
  logic               is_param;
  lls_pkg::char_t     rd_data;
  logic [NW-1:0]      unit_add;
  logic [SW-1:0]      unit_sum;
  logic               unit_lt;
  logic               cfg_wr;

  // configuration registers
  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel & cfg_penable & cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sev_r <= '0;
      exp_r <= 1'b0;
    end else if (cfg_wr) begin
      case (cfg_paddr[2])
        REG_SEVERITY:  sev_r <= cfg_pwdata[2:0];
        REG_EXPEDITED: exp_r <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[2])
      REG_SEVERITY:  cfg_prdata = lls_pkg::REG_WIDTH'(sev_r);
      REG_EXPEDITED: cfg_prdata = lls_pkg::REG_WIDTH'(exp_r);
      default:       cfg_prdata = '0;
    endcase
  end

  lls_fill_unit #(
    .LINE_LEN(LINE_LEN),
    .FW(FW),
    .NW(NW),
    .SW(SW)
  ) u_fill (
    .fill(fill_r),
    .addend(unit_add),
    .sum(unit_sum),
    .lt(unit_lt)
  );

  lls_param_store #(
    .DEPTH(CSI_MAX),
    .AW(AW)
  ) u_store (
    .clk(clk),
    .wr_en(wr_en),
    .wr_addr(cnt_r[AW-1:0]),
    .wr_data(in_text_byte),
    .rd_addr(idx_nxt),
    .rd_data(rd_data)
  );

  assign in_ready = (state_r == S_IDLE);
  assign can_emit = !out_valid_r || out_ready;
  assign is_param = (in_text_byte >= lls_pkg::CH_DIGIT_LO && in_text_byte <= lls_pkg::CH_DIGIT_HI)
                    || in_text_byte == lls_pkg::CH_SEMI;

  always_comb begin
    case (state_r)
      S_FIT:   unit_add = n_r;
      S_DATA:  unit_add = NW'(1);
      default: unit_add = '0;
    endcase
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    idx_nxt   = idx_r;
    fill_nxt  = fill_r;
    n_nxt     = n_r;
    byte_nxt  = byte_r;
    src_nxt   = src_r;
    csi_nxt   = csi_r;
    force_nxt = force_r;
    emit      = 1'b0;
    e_kind    = lls_pkg::KIND_DATA;
    e_byte    = '0;
    e_last    = 1'b0;
    wr_en     = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          byte_nxt = in_text_byte;
          if (phase_r == PH_TEXT) begin
            if (in_text_byte == lls_pkg::CH_ESC) begin
              phase_nxt = PH_ESC;
            end else if (in_text_byte == lls_pkg::CH_NL) begin
              if (fill_r != '0) begin
                state_nxt = S_END_NL;
              end
            end else begin
              n_nxt     = NW'(1);
              src_nxt   = SRC_FIN;
              csi_nxt   = 1'b0;
              force_nxt = 1'b0;
              state_nxt = S_FIT;
            end
          end else if (phase_r == PH_ESC) begin
            if (in_text_byte == lls_pkg::CH_LBRACKET) begin
              phase_nxt = PH_CSI;
            end else begin
              n_nxt     = NW'(2);
              src_nxt   = SRC_ESC;
              csi_nxt   = 1'b0;
              force_nxt = 1'b0;
              phase_nxt = PH_TEXT;
              state_nxt = S_FIT;
            end
          end else begin
            if (is_param) begin
              if (cnt_r < CW'(CSI_MAX)) begin
                wr_en   = 1'b1;
                cnt_nxt = cnt_r + CW'(1);
              end
            end else begin
              n_nxt     = NW'(cnt_r) + NW'(3);
              src_nxt   = SRC_ESC;
              csi_nxt   = 1'b1;
              force_nxt = (cnt_r == CW'(CSI_MAX));
              phase_nxt = PH_TEXT;
              state_nxt = S_FIT;
            end
          end
        end
      end
      S_FIT: begin
        if ((!unit_lt || force_r) && fill_r != '0) begin
          if (can_emit) begin
            emit      = 1'b1;
            e_kind    = lls_pkg::KIND_END;
            fill_nxt  = '0;
            state_nxt = S_CHK;
          end
        end else begin
          state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        if (fill_r != '0 && !unit_lt) begin
          if (can_emit) begin
            emit     = 1'b1;
            e_kind   = lls_pkg::KIND_END;
            fill_nxt = '0;
          end
        end else if (fill_r == '0) begin
          if (can_emit) begin
            emit      = 1'b1;
            e_kind    = lls_pkg::KIND_START;
            fill_nxt  = FW'(HEADER_BYTES);
            state_nxt = S_DATA;
          end
        end else begin
          state_nxt = S_DATA;
        end
      end
      S_DATA: begin
        if (can_emit) begin
          emit     = 1'b1;
          e_kind   = lls_pkg::KIND_DATA;
          fill_nxt = unit_sum[FW-1:0];
          e_last   = (src_r == SRC_FIN);
          case (src_r)
            SRC_ESC: e_byte = lls_pkg::CH_ESC;
            SRC_LB:  e_byte = lls_pkg::CH_LBRACKET;
            SRC_PAR: e_byte = rd_data;
            default: e_byte = byte_r;
          endcase
          case (src_r)
            SRC_ESC: begin
              src_nxt   = csi_r ? SRC_LB : SRC_FIN;
              state_nxt = S_CHK;
            end
            SRC_LB: begin
              src_nxt   = (cnt_r != '0) ? SRC_PAR : SRC_FIN;
              state_nxt = S_CHK;
            end
            SRC_PAR: begin
              if (CW'(idx_r) + CW'(1) == cnt_r) begin
                src_nxt = SRC_FIN;
                idx_nxt = '0;
              end else begin
                idx_nxt = idx_r + AW'(1);
              end
              state_nxt = S_CHK;
            end
            default: begin
              cnt_nxt   = '0;
              idx_nxt   = '0;
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_END_NL: begin
        if (can_emit) begin
          emit      = 1'b1;
          e_kind    = lls_pkg::KIND_END;
          e_last    = 1'b1;
          fill_nxt  = '0;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      phase_r <= PH_TEXT;
      cnt_r   <= '0;
      idx_r   <= '0;
      fill_r  <= '0;
      src_r   <= SRC_FIN;
      csi_r   <= 1'b0;
      force_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      idx_r   <= idx_nxt;
      fill_r  <= fill_nxt;
      src_r   <= src_nxt;
      csi_r   <= csi_nxt;
      force_r <= force_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r    <= n_nxt;
    byte_r <= byte_nxt;
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_kind_r <= e_kind;
      out_byte_r <= e_byte;
      out_sev_r  <= (e_kind == lls_pkg::KIND_START) ? sev_r : 3'd0;
      out_exp_r  <= (e_kind == lls_pkg::KIND_START) ? exp_r : 1'b0;
      out_last_r <= e_last;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_item_kind        = out_kind_r;
  assign out_data_byte        = out_byte_r;
  assign out_record_severity  = out_sev_r;
  assign out_record_expedited = out_exp_r;
  assign out_last_of_run      = out_last_r;

endmodule

// ===== rtl/lls_fill_unit.sv =====
// shared record fill adder and length compare
// depends on nothing; used by the top level sequencer
module lls_fill_unit #(
  parameter int LINE_LEN = 256,
  parameter int FW = 9,
  parameter int NW = 5,
  parameter int SW = 10
) (
  input  logic [FW-1:0] fill,
  input  logic [NW-1:0] addend,
  output logic [SW-1:0] sum,
  output logic          lt
);

  assign sum = SW'(fill) + SW'(addend);
  assign lt  = sum < SW'(LINE_LEN);

endmodule

// ===== rtl/lls_param_store.sv =====
// store for held csi parameter bytes, one write and one registered read port
// uses lls_pkg for the byte type
module lls_param_store #(
  parameter int DEPTH = 16,
  parameter int AW = 4
) (
  input  logic            clk,
  input  logic            wr_en,
  input  logic [AW-1:0]   wr_addr,
  input  lls_pkg::char_t  wr_data,
  input  logic [AW-1:0]   rd_addr,
  output lls_pkg::char_t  rd_data
);

  lls_pkg::char_t mem [DEPTH];
  lls_pkg::char_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== verif/log_line_splitter_csi_atomic_tb.sv =====
// testbench for log_line_splitter_csi_atomic: checks record start, data and end transactions
// against a built-in record splitter prediction under random idling and back-pressure
// depends on lls_pkg and the log_line_splitter_csi_atomic rtl
`timescale 1ns / 1ps

module log_line_splitter_csi_atomic_tb;

  localparam int LINE_LEN = 256;
  localparam int CSI_MAX = 16;
  localparam int HEADER_BYTES = 8;

  localparam logic [2:0] REG_SEVERITY = 3'd0;
  localparam logic [2:0] REG_EXPEDITED = 3'd4;

  localparam int SETTLE_CYCLES = 20;
  localparam int HOLD_CYCLES = 400;
  localparam int HOLD_AFTER = 30;
  localparam int WATCHDOG_LIMIT = 4000;

  localparam lls_pkg::char_t CH_LETTER_A = 8'h41;
  localparam lls_pkg::char_t CH_LETTER_H = 8'h48;
  localparam lls_pkg::char_t CH_LETTER_M = 8'h6D;

  localparam lls_pkg::char_t OPENING_TEXT [24] = '{
    lls_pkg::CH_NL, 8'h00, 8'hFF, lls_pkg::CH_NL,
    lls_pkg::CH_ESC, CH_LETTER_A,
    lls_pkg::CH_ESC, lls_pkg::CH_LBRACKET, lls_pkg::CH_DIGIT_LO + 8'd1, lls_pkg::CH_SEMI,
    lls_pkg::CH_DIGIT_LO + 8'd3, lls_pkg::CH_DIGIT_HI,
    CH_LETTER_M,
    lls_pkg::CH_ESC, lls_pkg::CH_LBRACKET, CH_LETTER_H,
    lls_pkg::CH_ESC, lls_pkg::CH_LBRACKET, lls_pkg::CH_NL,
    lls_pkg::CH_ESC, lls_pkg::CH_LBRACKET, lls_pkg::CH_DIGIT_LO, lls_pkg::CH_ESC,
    lls_pkg::CH_NL
  };

  typedef enum logic [1:0] {ESC_NONE, ESC_SEEN, ESC_CSI, ESC_SPARE} esc_state_t;

  typedef struct packed {
    lls_pkg::kind_t kind;
    lls_pkg::char_t data;
    logic [2:0]     severity;
    logic           expedited;
    logic           last;
  } record_item_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_text_byte = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_item_kind;
  logic [7:0]  out_data_byte;
  logic [2:0]  out_record_severity;
  logic        out_record_expedited;
  logic        out_last_of_run;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = 3'd0;
  logic [31:0] cfg_pwdata = 32'd0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  lls_pkg::char_t text_queue[$];
  record_item_t   expected_items[$];

  logic [2:0]     severity_cfg = 3'd0;
  logic           expedited_cfg = 1'b0;
  esc_state_t     esc_state = ESC_NONE;
  int unsigned    held_count = 0;
  lls_pkg::char_t held_params [CSI_MAX];
  int unsigned    record_fill = 0;
  int unsigned    run_len = 0;

  int unsigned    send_idle_pct = 0;
  int unsigned    recv_stall_pct = 0;
  int unsigned    quiet_cycles = 0;
  int unsigned    errors = 0;
  int unsigned    results_seen = 0;
  int unsigned    hold_left = 0;
  bit             hold_done = 1'b0;
  record_item_t   seen_item;
  record_item_t   oldest_item;

  log_line_splitter_csi_atomic #(
    .LINE_LEN(LINE_LEN),
    .CSI_MAX(CSI_MAX),
    .HEADER_BYTES(HEADER_BYTES)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_text_byte(in_text_byte),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item_kind(out_item_kind),
    .out_data_byte(out_data_byte),
    .out_record_severity(out_record_severity),
    .out_record_expedited(out_record_expedited),
    .out_last_of_run(out_last_of_run),
    .cfg_psel(cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr),
    .cfg_pwdata(cfg_pwdata),
    .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic bit is_param_char(lls_pkg::char_t c);
    return (c >= lls_pkg::CH_DIGIT_LO && c <= lls_pkg::CH_DIGIT_HI) || c == lls_pkg::CH_SEMI;
  endfunction

  function automatic void append_char(lls_pkg::char_t c);
    text_queue.insert(text_queue.size(), c);
  endfunction

  // record splitter prediction

  function automatic void push_item(lls_pkg::kind_t kind, lls_pkg::char_t data,
                                    logic [2:0] sev, logic expd);
    record_item_t item;
    item = '{kind: kind, data: data, severity: sev, expedited: expd, last: 1'b0};
    expected_items.insert(expected_items.size(), item);
    run_len++;
  endfunction

  function automatic void close_record();
    if (record_fill != 0) begin
      push_item(lls_pkg::KIND_END, 8'h00, 3'd0, 1'b0);
      record_fill = 0;
    end
  endfunction

  function automatic bit room_for(int unsigned n);
    return record_fill + n < LINE_LEN;
  endfunction

  function automatic void place_char(lls_pkg::char_t c);
    if (record_fill != 0 && record_fill >= LINE_LEN) close_record();
    if (record_fill == 0) begin
      push_item(lls_pkg::KIND_START, 8'h00, severity_cfg, expedited_cfg);
      record_fill = HEADER_BYTES;
    end
    push_item(lls_pkg::KIND_DATA, c, 3'd0, 1'b0);
    record_fill++;
  endfunction

  function automatic void split_text_byte(lls_pkg::char_t c);
    record_item_t tail;
    run_len = 0;
    case (esc_state)
      ESC_NONE: begin
        if (c == lls_pkg::CH_ESC) begin
          esc_state = ESC_SEEN;
        end else if (c == lls_pkg::CH_NL) begin
          close_record();
        end else begin
          if (!room_for(1)) close_record();
          place_char(c);
        end
      end
      ESC_SEEN: begin
        if (c == lls_pkg::CH_LBRACKET) begin
          esc_state = ESC_CSI;
        end else begin
          if (!room_for(2)) close_record();
          place_char(lls_pkg::CH_ESC);
          place_char(c);
          esc_state = ESC_NONE;
        end
      end
      default: begin
        if (is_param_char(c)) begin
          if (held_count < CSI_MAX) begin
            held_params[held_count] = c;
            held_count++;
          end
        end else begin
          if (held_count >= CSI_MAX || !room_for(3 + held_count)) close_record();
          place_char(lls_pkg::CH_ESC);
          place_char(lls_pkg::CH_LBRACKET);
          for (int unsigned i = 0; i < held_count && i < CSI_MAX; i++)
            place_char(held_params[i]);
          place_char(c);
          esc_state = ESC_NONE;
          held_count = 0;
        end
      end
    endcase
    if (run_len != 0) begin
      tail = expected_items.pop_back();
      tail.last = 1'b1;
      expected_items.insert(expected_items.size(), tail);
    end
  endfunction

  // input driver

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) split_text_byte(in_text_byte);
      if (!in_valid || in_ready) begin
        if (text_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_text_byte <= text_queue.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        seen_item = '{kind: out_item_kind, data: out_data_byte,
                      severity: out_record_severity, expedited: out_record_expedited,
                      last: out_last_of_run};
        results_seen++;
        if (expected_items.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected transaction: kind %0d byte %02h sev %0d exp %0d last %0d",
                     seen_item.kind, seen_item.data, seen_item.severity,
                     seen_item.expedited, seen_item.last);
        end else begin
          oldest_item = expected_items.pop_front();
          if (seen_item.kind !== oldest_item.kind || seen_item.data !== oldest_item.data ||
              seen_item.severity !== oldest_item.severity ||
              seen_item.expedited !== oldest_item.expedited ||
              seen_item.last !== oldest_item.last) begin
            errors++;
            if (errors <= 10)
              $display("mismatch at result %0d: expected kind %0d byte %02h sev %0d",
                       results_seen, oldest_item.kind, oldest_item.data,
                       oldest_item.severity,
                       " exp %0d last %0d, got kind %0d byte %02h sev %0d",
                       oldest_item.expedited, oldest_item.last,
                       seen_item.kind, seen_item.data, seen_item.severity,
                       " exp %0d last %0d",
                       seen_item.expedited, seen_item.last);
          end
        end
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (!hold_done && results_seen >= HOLD_AFTER) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  // watchdog on handshake progress

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // stimulus

  task automatic write_reg(input logic [2:0] addr, input logic [31:0] value);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= addr;
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    case (addr)
      REG_SEVERITY:  severity_cfg = value[2:0];
      REG_EXPEDITED: expedited_cfg = value[0];
      default: ;
    endcase
  endtask

  function automatic lls_pkg::char_t plain_char();
    lls_pkg::char_t c;
    do c = lls_pkg::char_t'($urandom_range(0, 255));
    while (c == lls_pkg::CH_ESC || c == lls_pkg::CH_NL);
    return c;
  endfunction

  function automatic lls_pkg::char_t param_char();
    int unsigned r;
    r = $urandom_range(0, 10);
    return (r == 10) ? lls_pkg::CH_SEMI : lls_pkg::CH_DIGIT_LO + lls_pkg::char_t'(r);
  endfunction

  function automatic lls_pkg::char_t final_char();
    lls_pkg::char_t c;
    if ($urandom_range(0, 3) != 0) return lls_pkg::char_t'($urandom_range(8'h40, 8'h7E));
    do c = lls_pkg::char_t'($urandom_range(0, 255)); while (is_param_char(c));
    return c;
  endfunction

  task automatic add_random(input int unsigned fill_to, input int unsigned nl_pct);
    int unsigned pick;
    int unsigned n;
    lls_pkg::char_t c;
    while (text_queue.size() < fill_to) begin
      pick = $urandom_range(0, 99);
      if (pick < nl_pct) begin
        append_char(lls_pkg::CH_NL);
      end else if (pick < 55) begin
        n = $urandom_range(1, 8);
        repeat (n) append_char(plain_char());
      end else if (pick < 72) begin
        n = ($urandom_range(0, 4) == 0) ? $urandom_range(14, 20) : $urandom_range(0, 5);
        append_char(lls_pkg::CH_ESC);
        append_char(lls_pkg::CH_LBRACKET);
        repeat (n) append_char(param_char());
        append_char(final_char());
      end else if (pick < 80) begin
        do c = lls_pkg::char_t'($urandom_range(0, 255)); while (c == lls_pkg::CH_LBRACKET);
        append_char(lls_pkg::CH_ESC);
        append_char(c);
      end else begin
        append_char(lls_pkg::char_t'($urandom_range(0, 255)));
      end
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (text_queue.size() != 0 || in_valid || expected_items.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // no idling, receiver hold-off early in the random part
    write_reg(REG_SEVERITY, 32'd7);
    write_reg(REG_EXPEDITED, 32'd1);
    @(negedge clk);
    foreach (OPENING_TEXT[i]) append_char(OPENING_TEXT[i]);
    add_random(95, 2);
    wait_drained();

    write_reg(REG_SEVERITY, 32'd0);
    write_reg(REG_EXPEDITED, 32'd0);
    send_idle_pct = 87;
    recv_stall_pct = 0;
    @(negedge clk);
    add_random(90, 2);
    wait_drained();

    // long lines with no inserted newlines, so records grow long and may overflow
    write_reg(REG_SEVERITY, 32'd5);
    write_reg(REG_EXPEDITED, 32'd1);
    send_idle_pct = 0;
    recv_stall_pct = 87;
    @(negedge clk);
    add_random(120, 0);
    wait_drained();

    write_reg(REG_SEVERITY, 32'd2);
    write_reg(REG_EXPEDITED, 32'd0);
    send_idle_pct = 12;
    recv_stall_pct = 12;
    @(negedge clk);
    add_random(90, 3);
    wait_drained();

    write_reg(REG_SEVERITY, 32'd7);
    write_reg(REG_EXPEDITED, 32'd0);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    @(negedge clk);
    add_random(60, 2);
    wait_drained();

    if (errors == 0 && expected_items.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/lls_pkg.sv
rtl/lls_fill_unit.sv
rtl/lls_param_store.sv
rtl/log_line_splitter_csi_atomic.sv
verif/log_line_splitter_csi_atomic_tb.sv
